// ===== rtl/core/cwd_pkg.sv =====
// ----------------------------------------------------------------------------
// cwd_pkg
// Shared types, codes and constants for the camera window, decimation and
// frame buffer pool block.
// ----------------------------------------------------------------------------
package cwd_pkg;

   // buffer pool geometry
   localparam int POOL_DEPTH = 4;
   localparam int BUF_W      = 2;
   localparam int CNT_W      = $clog2(POOL_DEPTH + 1);

   // field widths
   localparam int POS_W   = 10;
   localparam int END_W   = 11;
   localparam int PER_W   = 8;
   localparam int PIX_W   = 8;
   localparam int FNUM_W  = 16;
   localparam int CSR_A_W = 3;
   localparam int CSR_D_W = 11;
   localparam int REM_CNT_W = $clog2(FNUM_W + 1);

   // highest sensor row before the counter saturates
   localparam logic [POS_W-1:0] ROW_MAX = {POS_W{1'b1}};

   // register indexes
   localparam logic [CSR_A_W-1:0] REG_NATIVE_COLS  = 3'd0;
   localparam logic [CSR_A_W-1:0] REG_NATIVE_ROWS  = 3'd1;
   localparam logic [CSR_A_W-1:0] REG_START_COL    = 3'd2;
   localparam logic [CSR_A_W-1:0] REG_END_COL      = 3'd3;
   localparam logic [CSR_A_W-1:0] REG_COL_PERIOD   = 3'd4;
   localparam logic [CSR_A_W-1:0] REG_ROW_PERIOD   = 3'd5;
   localparam logic [CSR_A_W-1:0] REG_FRAME_PERIOD = 3'd6;

   // register reset values
   localparam logic [POS_W-1:0] RST_NATIVE_COLS  = 10'd160;
   localparam logic [POS_W-1:0] RST_NATIVE_ROWS  = 10'd120;
   localparam logic [POS_W-1:0] RST_START_COL    = 10'd20;
   localparam logic [END_W-1:0] RST_END_COL      = 11'd140;
   localparam logic [PER_W-1:0] RST_COL_PERIOD   = 8'd4;
   localparam logic [PER_W-1:0] RST_ROW_PERIOD   = 8'd4;
   localparam logic [PER_W-1:0] RST_FRAME_PERIOD = 8'd1;

   // request kinds
   typedef enum logic [1:0] {
      OP_FRAME_START = 2'd0,
      OP_PIXEL       = 2'd1,
      OP_RETURN      = 2'd2,
      OP_TAKE        = 2'd3
   } op_type;

   // phase recompute sequencer
   typedef enum logic [1:0] {
      RC_WAIT  = 2'd0,
      RC_RUN   = 2'd1,
      RC_READY = 2'd2
   } rc_state_type;

   // commands into the buffer pool
   typedef struct packed {
      logic              ret_valid;
      logic [BUF_W-1:0]  ret_buf;
      logic              take;
      logic              push;
      logic [BUF_W-1:0]  push_buf;
      logic [FNUM_W-1:0] push_num;
      logic              acquire;
   } pool_cmd_type;

   // answers from the buffer pool
   typedef struct packed {
      logic              acq_valid;
      logic [BUF_W-1:0]  acq_buf;
      logic              take_valid;
      logic [BUF_W-1:0]  take_buf;
      logic [FNUM_W-1:0] take_num;
      logic              frames_ready;
   } pool_rsp_type;

   // one result item
   typedef struct packed {
      logic              write_valid;
      logic [1:0]        write_buffer;
      logic [POS_W-1:0]  out_row;
      logic [POS_W-1:0]  out_col;
      logic [PIX_W-1:0]  pixel_out;
      logic              row_done;
      logic              frame_done;
      logic [FNUM_W-1:0] frame_number;
      logic              take_valid;
      logic [1:0]        take_buffer;
      logic              frames_ready;
   } rsp_type;

   // ring index: base plus offset, wrapped at the pool depth
   function automatic logic [BUF_W-1:0] ring_add(logic [BUF_W-1:0] base,
                                                 logic [CNT_W-1:0] ofs);
      logic [CNT_W:0] sum;
      sum = (CNT_W+1)'(base) + (CNT_W+1)'(ofs);
      if (sum >= (CNT_W+1)'(POOL_DEPTH)) begin
         sum = sum - (CNT_W+1)'(POOL_DEPTH);
      end
      return sum[BUF_W-1:0];
   endfunction

endpackage

// ===== rtl/core/cwd_rem.sv =====
// ----------------------------------------------------------------------------
// cwd_rem
// Iterative remainder unit: one restoring step per cycle over a 16-bit
// dividend and an 8-bit nonzero divisor.
// ----------------------------------------------------------------------------
module cwd_rem
   import cwd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [FNUM_W-1:0] dividend,
   input  logic [PER_W-1:0]  divisor,
   output logic              busy,
   output logic [PER_W-1:0]  remainder
);

   logic [REM_CNT_W-1:0] cnt_ff;
   logic [FNUM_W-1:0]    dvd_ff;
   logic [PER_W-1:0]     div_ff;
   logic [PER_W-1:0]     rem_ff;
   logic [PER_W-1:0]     rem_in;
   logic [PER_W:0]       trial;

   // one shift-and-subtract step
   always_comb begin
      trial = {rem_ff, dvd_ff[FNUM_W-1]};
      if (trial >= {1'b0, div_ff}) begin
         trial = trial - {1'b0, div_ff};
      end
      rem_in = trial[PER_W-1:0];
   end

   // step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (start) begin
         cnt_ff <= REM_CNT_W'(FNUM_W);
      end else if (busy) begin
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   // operands and partial remainder
   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= dividend;
         div_ff <= divisor;
         rem_ff <= '0;
      end else if (busy) begin
         dvd_ff <= {dvd_ff[FNUM_W-2:0], 1'b0};
         rem_ff <= rem_in;
      end
   end

   assign busy      = (cnt_ff != '0);
   assign remainder = rem_ff;

endmodule

// ===== rtl/core/cwd_pool.sv =====
// ----------------------------------------------------------------------------
// cwd_pool
// Frame buffer pool: free queue, full frame queue and per-buffer frame
// numbers. Answers are combinational on the command; state moves at the edge.
// ----------------------------------------------------------------------------
module cwd_pool
   import cwd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  pool_cmd_type cmd,
   output pool_rsp_type prsp
);

   logic [BUF_W-1:0]  free_q_ff [POOL_DEPTH];
   logic [BUF_W-1:0]  free_head_ff, free_head_in;
   logic [CNT_W-1:0]  free_cnt_ff, free_cnt_in;
   logic [BUF_W-1:0]  full_q_ff [POOL_DEPTH];
   logic [BUF_W-1:0]  full_head_ff, full_head_in;
   logic [CNT_W-1:0]  full_cnt_ff, full_cnt_in;
   logic [FNUM_W-1:0] bfn_ff [POOL_DEPTH];

   logic [BUF_W-1:0]  free_rd, full_rd;
   logic              free_has, ret_ok, push_ok, pop_free, pop_full, acq_full, take_ok;
   logic [CNT_W-1:0]  full_cnt_p;

   assign free_rd = free_q_ff[free_head_ff];
   assign full_rd = full_q_ff[full_head_ff];

   // queue decisions: a frame push lands before the acquire looks at the queue
   always_comb begin
      free_has   = (free_cnt_ff != '0);
      ret_ok     = cmd.ret_valid && (CNT_W'(cmd.ret_buf) < CNT_W'(POOL_DEPTH)) &&
                   (free_cnt_ff < CNT_W'(POOL_DEPTH));
      push_ok    = cmd.push && (full_cnt_ff < CNT_W'(POOL_DEPTH));
      full_cnt_p = full_cnt_ff + CNT_W'(push_ok);
      pop_free   = cmd.acquire && free_has;
      acq_full   = cmd.acquire && !free_has && (full_cnt_p != '0);
      take_ok    = cmd.take && (full_cnt_ff != '0);
      pop_full   = acq_full || take_ok;

      free_head_in = pop_free ? ring_add(free_head_ff, CNT_W'(1)) : free_head_ff;
      free_cnt_in  = free_cnt_ff + CNT_W'(ret_ok) - CNT_W'(pop_free);
      full_head_in = pop_full ? ring_add(full_head_ff, CNT_W'(1)) : full_head_ff;
      full_cnt_in  = full_cnt_p - CNT_W'(pop_full);

      prsp.acq_valid    = pop_free || acq_full;
      if (free_has) begin
         prsp.acq_buf = free_rd;
      end else if (full_cnt_ff == '0) begin
         prsp.acq_buf = cmd.push_buf;
      end else begin
         prsp.acq_buf = full_rd;
      end
      prsp.take_valid   = take_ok;
      prsp.take_buf     = take_ok ? full_rd : '0;
      prsp.take_num     = take_ok ? bfn_ff[full_rd] : '0;
      prsp.frames_ready = (full_cnt_in != '0);
   end

   // queue pointers, free queue preloaded with buffers 1 and up
   always_ff @(posedge clock) begin
      if (reset) begin
         free_head_ff <= '0;
         free_cnt_ff  <= CNT_W'(POOL_DEPTH - 1);
         full_head_ff <= '0;
         full_cnt_ff  <= '0;
         for (int i = 0; i < POOL_DEPTH; i++) begin
            free_q_ff[i] <= BUF_W'((i + 1) % POOL_DEPTH);
         end
      end else begin
         free_head_ff <= free_head_in;
         free_cnt_ff  <= free_cnt_in;
         full_head_ff <= full_head_in;
         full_cnt_ff  <= full_cnt_in;
         if (ret_ok) begin
            free_q_ff[ring_add(free_head_ff, free_cnt_ff)] <= cmd.ret_buf;
         end
      end
   end

   // full queue entries and frame numbers
   always_ff @(posedge clock) begin
      if (push_ok) begin
         full_q_ff[ring_add(full_head_ff, full_cnt_ff)] <= cmd.push_buf;
      end
      if (cmd.push) begin
         bfn_ff[cmd.push_buf] <= cmd.push_num;
      end
   end

endmodule

// ===== rtl/core/cwd_rsp_buf.sv =====
// ----------------------------------------------------------------------------
// cwd_rsp_buf
// Two-entry result buffer between the capture logic and the response channel.
// ----------------------------------------------------------------------------
module cwd_rsp_buf
   import cwd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  rsp_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_data
);

   rsp_type    slot0_ff, slot1_ff;
   logic [1:0] cnt_ff;
   logic       push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data  = slot0_ff;
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end

   // slots
   always_ff @(posedge clock) begin
      if (pop) begin
         slot0_ff <= (push && cnt_ff == 2'd1) ? in_data : slot1_ff;
         if (push && cnt_ff == 2'd2) begin
            slot1_ff <= in_data;
         end
      end else if (push) begin
         if (cnt_ff == 2'd0) begin
            slot0_ff <= in_data;
         end else begin
            slot1_ff <= in_data;
         end
      end
   end

endmodule

// ===== rtl/core/camera_window_decimate_frame_pool.sv =====
// ----------------------------------------------------------------------------
// camera_window_decimate_frame_pool
// Sensor window crop and row/column/frame decimation with a frame buffer pool.
// ----------------------------------------------------------------------------
// Each taken request puts a result into a two-entry buffer that decouples the response
// side and offers it on rsp_tvalid. One request per cycle unless the buffer is full, a
// csr write is offered or a recompute runs; capture state and pool update as the
// request is taken. Reset and every csr write start a phase recompute in four parallel
// remainder units, with req_tready low until it ends (restarting on a further write).
// Reset is synchronous, active high; csr writes are always taken.
module camera_window_decimate_frame_pool
   import cwd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [15:0]        req_tdata,   // pixel_value[7:0], return_buffer[9:8]
   input  logic [1:0]         req_tuser,   // operation[1:0]
   // result channel
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [55:0]        rsp_tdata,   // write_valid, write_buffer, out_row,
                                           // out_col, pixel_out, row_done,
                                           // frame_number, take_valid,
                                           // take_buffer, frames_ready
   output logic               rsp_tlast,   // frame_done
   // configuration write channel
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [CSR_A_W-1:0] csr_index,
   input  logic [CSR_D_W-1:0] csr_data
);

   // configuration registers
   logic [POS_W-1:0] ncols_ff, nrows_ff, start_ff;
   logic [END_W-1:0] end_ff;
   logic [PER_W-1:0] cper_ff, rper_ff, fper_ff;

   // capture state
   logic              capture_ff, capture_in;
   logic [FNUM_W-1:0] fcount_ff, fcount_in;
   logic [POS_W-1:0]  srow_ff, srow_in, scol_ff, scol_in;
   logic [POS_W-1:0]  krow_ff, krow_in, kcol_ff, kcol_in;
   logic [BUF_W-1:0]  cbuf_ff, cbuf_in;
   logic              cvalid_ff, cvalid_in;
   logic [PER_W-1:0]  rphase_ff, rphase_in, cphase_ff, cphase_in, fphase_ff, fphase_in;
   logic [PER_W-1:0]  evoff_ff;

   // recompute sequencer
   rc_state_type rc_state_ff, rc_state_in;
   logic         rc_start, rc_load, rc_ready;
   logic [3:0]   rem_busy;
   logic [PER_W-1:0] rem_row, rem_col, rem_frame, rem_ev;

   // derived configuration
   logic [POS_W-1:0] nc, nr, evcol, col_rel, ev_span;
   logic [PER_W-1:0] cp, rp, fp;
   logic [END_W-1:0] ec0, ec;
   logic             has_win;

   logic         req_fire, csr_fire, buf_ready;
   op_type       op;
   pool_cmd_type cmd;
   pool_rsp_type prsp;
   rsp_type      rsp_in, rsp_out;

   // zero sizes and periods act as one; window clipped to the row
   always_comb begin
      nc      = (ncols_ff == '0) ? POS_W'(1) : ncols_ff;
      nr      = (nrows_ff == '0) ? POS_W'(1) : nrows_ff;
      cp      = (cper_ff == '0) ? PER_W'(1) : cper_ff;
      rp      = (rper_ff == '0) ? PER_W'(1) : rper_ff;
      fp      = (fper_ff == '0) ? PER_W'(1) : fper_ff;
      ec0     = (end_ff != '0) ? end_ff - 1'b1 : '0;
      ec      = (ec0 > {1'b0, nc}) ? {1'b0, nc} : ec0;
      has_win = (ec > {1'b0, start_ff});
      ev_span = has_win ? POS_W'(ec - 1'b1 - {1'b0, start_ff}) : '0;
      evcol   = has_win ? POS_W'(ec - 1'b1 - END_W'(evoff_ff)) : nc - 1'b1;
      col_rel = (scol_ff >= start_ff) ? scol_ff - start_ff : '0;
   end

   // handshakes
   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid;
   assign req_tready = rc_ready && buf_ready && !csr_valid;
   assign req_fire  = req_tvalid && req_tready;
   assign op        = op_type'(req_tuser);

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         ncols_ff <= RST_NATIVE_COLS;
         nrows_ff <= RST_NATIVE_ROWS;
         start_ff <= RST_START_COL;
         end_ff   <= RST_END_COL;
         cper_ff  <= RST_COL_PERIOD;
         rper_ff  <= RST_ROW_PERIOD;
         fper_ff  <= RST_FRAME_PERIOD;
      end else if (csr_fire) begin
         case (csr_index)
            REG_NATIVE_COLS:  ncols_ff <= csr_data[POS_W-1:0];
            REG_NATIVE_ROWS:  nrows_ff <= csr_data[POS_W-1:0];
            REG_START_COL:    start_ff <= csr_data[POS_W-1:0];
            REG_END_COL:      end_ff   <= csr_data[END_W-1:0];
            REG_COL_PERIOD:   cper_ff  <= csr_data[PER_W-1:0];
            REG_ROW_PERIOD:   rper_ff  <= csr_data[PER_W-1:0];
            REG_FRAME_PERIOD: fper_ff  <= csr_data[PER_W-1:0];
            default: ;
         endcase
      end
   end

   // recompute sequencer: next state
   always_comb begin
      rc_state_in = rc_state_ff;
      case (rc_state_ff)
         RC_WAIT:  rc_state_in = csr_fire ? RC_WAIT : RC_RUN;
         RC_RUN: begin
            if (csr_fire) begin
               rc_state_in = RC_WAIT;
            end else if (rem_busy == '0) begin
               rc_state_in = RC_READY;
            end
         end
         RC_READY: rc_state_in = csr_fire ? RC_WAIT : RC_READY;
         default:  rc_state_in = RC_WAIT;
      endcase
   end

   // recompute sequencer: outputs
   always_comb begin
      rc_start = 1'b0;
      rc_load  = 1'b0;
      rc_ready = 1'b0;
      case (rc_state_ff)
         RC_WAIT:  rc_start = 1'b1;
         RC_RUN:   rc_load  = (rem_busy == '0) && !csr_fire;
         RC_READY: rc_ready = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rc_state_ff <= RC_WAIT;
      end else begin
         rc_state_ff <= rc_state_in;
      end
   end

   // phase remainders: row, column, frame and window end offset
   cwd_rem u_rem_row (
      .clock(clock), .reset(reset), .start(rc_start),
      .dividend(FNUM_W'(srow_ff)), .divisor(rp),
      .busy(rem_busy[0]), .remainder(rem_row)
   );
   cwd_rem u_rem_col (
      .clock(clock), .reset(reset), .start(rc_start),
      .dividend(FNUM_W'(col_rel)), .divisor(cp),
      .busy(rem_busy[1]), .remainder(rem_col)
   );
   cwd_rem u_rem_frame (
      .clock(clock), .reset(reset), .start(rc_start),
      .dividend(fcount_ff), .divisor(fp),
      .busy(rem_busy[2]), .remainder(rem_frame)
   );
   cwd_rem u_rem_ev (
      .clock(clock), .reset(reset), .start(rc_start),
      .dividend(FNUM_W'(ev_span)), .divisor(cp),
      .busy(rem_busy[3]), .remainder(rem_ev)
   );

   // request processing
   always_comb begin
      logic [END_W-1:0] scol_inc;
      logic             wrap, row_kept, keep, row_event, last_row;
      logic [PER_W-1:0] rph_inc, cph_inc, fph_inc;

      capture_in = capture_ff;
      fcount_in  = fcount_ff;
      srow_in    = srow_ff;
      scol_in    = scol_ff;
      krow_in    = krow_ff;
      kcol_in    = kcol_ff;
      cbuf_in    = cbuf_ff;
      cvalid_in  = cvalid_ff;
      rphase_in  = rphase_ff;
      cphase_in  = cphase_ff;
      fphase_in  = fphase_ff;
      cmd        = '0;
      rsp_in     = '0;

      rph_inc   = rphase_ff + 1'b1;
      cph_inc   = cphase_ff + 1'b1;
      fph_inc   = fphase_ff + 1'b1;
      scol_inc  = {1'b0, scol_ff} + 1'b1;
      wrap      = (scol_inc >= {1'b0, nc});
      row_kept  = capture_ff && (srow_ff < nr) && (rphase_ff == '0);
      keep      = row_kept && has_win && (scol_ff >= start_ff) &&
                  ({1'b0, scol_ff} < ec) && (cphase_ff == '0);
      row_event = row_kept && (scol_ff == evcol);
      last_row  = ({1'b0, srow_ff} + END_W'(rp)) >= {1'b0, nr};

      if (req_fire) begin
         case (op)
            OP_FRAME_START: begin
               fcount_in = fcount_ff + 1'b1;
               fphase_in = ((fcount_ff == '1) || (fph_inc == fp)) ? '0 : fph_inc;
               capture_in = (fphase_in == '0);
               srow_in   = '0;
               scol_in   = '0;
               krow_in   = '0;
               kcol_in   = '0;
               rphase_in = '0;
               cphase_in = '0;
               // retry buffer acquisition
               if (!cvalid_ff) begin
                  cmd.acquire = 1'b1;
                  cvalid_in   = prsp.acq_valid;
                  if (prsp.acq_valid) begin
                     cbuf_in = prsp.acq_buf;
                  end
               end
            end
            OP_PIXEL: begin
               // pixel write
               if (keep) begin
                  if (cvalid_ff) begin
                     rsp_in.write_valid  = 1'b1;
                     rsp_in.write_buffer = 2'(cbuf_ff);
                     rsp_in.out_row      = krow_ff;
                     rsp_in.out_col      = kcol_ff;
                     rsp_in.pixel_out    = req_tdata[PIX_W-1:0];
                  end
                  kcol_in = kcol_ff + 1'b1;
               end
               // end of a kept row or of the frame
               if (row_event) begin
                  if (last_row) begin
                     rsp_in.frame_done   = 1'b1;
                     rsp_in.frame_number = fcount_ff;
                     if (cvalid_ff) begin
                        cmd.push     = 1'b1;
                        cmd.push_buf = cbuf_ff;
                        cmd.push_num = fcount_ff;
                        cmd.acquire  = 1'b1;
                        cvalid_in    = prsp.acq_valid;
                        if (prsp.acq_valid) begin
                           cbuf_in = prsp.acq_buf;
                        end
                     end
                     krow_in    = '0;
                     capture_in = 1'b0;
                  end else begin
                     rsp_in.row_done = 1'b1;
                     krow_in = krow_ff + 1'b1;
                  end
                  kcol_in = '0;
               end
               // sensor position and phases
               if (wrap) begin
                  scol_in = '0;
                  if (srow_ff < ROW_MAX) begin
                     srow_in   = srow_ff + 1'b1;
                     rphase_in = (rph_inc == rp) ? '0 : rph_inc;
                  end
               end else begin
                  scol_in = scol_inc[POS_W-1:0];
               end
               if (scol_in == start_ff) begin
                  cphase_in = '0;
               end else if ((scol_ff >= start_ff) && !wrap) begin
                  cphase_in = (cph_inc == cp) ? '0 : cph_inc;
               end
            end
            OP_RETURN: begin
               cmd.ret_valid = 1'b1;
               cmd.ret_buf   = req_tdata[PIX_W +: BUF_W];
            end
            OP_TAKE: begin
               cmd.take = 1'b1;
               rsp_in.take_valid   = prsp.take_valid;
               rsp_in.take_buffer  = 2'(prsp.take_buf);
               rsp_in.frame_number = prsp.take_num;
            end
            default: ;
         endcase
      end
      rsp_in.frames_ready = prsp.frames_ready;
   end

   // capture state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         capture_ff <= 1'b0;
         fcount_ff  <= '1;
         srow_ff    <= '0;
         scol_ff    <= '0;
         krow_ff    <= '0;
         kcol_ff    <= '0;
         cbuf_ff    <= '0;
         cvalid_ff  <= 1'b1;
         rphase_ff  <= '0;
         cphase_ff  <= '0;
         fphase_ff  <= '0;
         evoff_ff   <= '0;
      end else if (rc_load) begin
         rphase_ff <= rem_row;
         cphase_ff <= rem_col;
         fphase_ff <= rem_frame;
         evoff_ff  <= rem_ev;
      end else if (req_fire) begin
         capture_ff <= capture_in;
         fcount_ff  <= fcount_in;
         srow_ff    <= srow_in;
         scol_ff    <= scol_in;
         krow_ff    <= krow_in;
         kcol_ff    <= kcol_in;
         cbuf_ff    <= cbuf_in;
         cvalid_ff  <= cvalid_in;
         rphase_ff  <= rphase_in;
         cphase_ff  <= cphase_in;
         fphase_ff  <= fphase_in;
      end
   end

   cwd_pool u_pool (
      .clock(clock),
      .reset(reset),
      .cmd  (cmd),
      .prsp (prsp)
   );

   cwd_rsp_buf u_rsp_buf (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_fire),
      .in_ready (buf_ready),
      .in_data  (rsp_in),
      .out_valid(rsp_tvalid),
      .out_ready(rsp_tready),
      .out_data (rsp_out)
   );

   // result packing
   assign rsp_tdata = {4'b0, rsp_out.frames_ready, rsp_out.take_buffer,
                       rsp_out.take_valid, rsp_out.frame_number, rsp_out.row_done,
                       rsp_out.pixel_out, rsp_out.out_col, rsp_out.out_row,
                       rsp_out.write_buffer, rsp_out.write_valid};
   assign rsp_tlast = rsp_out.frame_done;

endmodule

// ===== rtl/core/cwd_checker.sv =====
// ----------------------------------------------------------------------------
// cwd_prop_checker
// Port-level checks for the camera window, decimation and frame pool block.
// ----------------------------------------------------------------------------
module cwd_prop_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata,
   input logic        rsp_tlast
);

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // row end and frame end never flagged together
   a_done_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tlast && rsp_tdata[31]))
      else $error("row_done and frame_done both set");

   // no write: write fields are zero; frame number only with frame end or take
   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] && !rsp_tlast && !rsp_tdata[48]
      |-> (rsp_tdata[30:1] == '0) && (rsp_tdata[47:32] == '0) &&
          (rsp_tdata[50:49] == '0))
      else $error("stale fields in result");

   // after reset nothing is taken or offered while phases are recomputed
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !req_tready && !rsp_tvalid)
      else $error("activity right after reset");

endmodule

bind camera_window_decimate_frame_pool cwd_prop_checker u_cwd_checker (.*);
